// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, held off while reset is active.
`define LRCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assert that an antecedent is followed by a consequent on the next edge.
`define LRCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  `LRCI_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- hdl/lrci_pkg.sv -----
// ----------------------------------------------------------------------------
// lrci_pkg
// Shared types and constants of the line rasterizer with color interpolation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrci_pkg;

  // Command codes of an input word
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Fixed point weight and color channel sizes
  localparam int unsigned W_BITS  = 16;
  localparam int unsigned CH_BITS = 8;
  localparam int unsigned CH_NUM  = 4;

  // Controller to datapath commands
  typedef struct packed {
    logic take;        // latch an accepted input word
    logic prep;        // set up divider for the current pixel
    logic div_step;    // one restoring divide iteration
    logic blend_step;  // blend one color channel
    logic push;        // move the pixel into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_step;      // input word requests a pixel
    logic line_active;  // a line is loaded with pixels left
    logic den_zero;     // zero span, weight is zero
    logic div_last;     // final divide iteration
    logic blend_last;   // final channel
    logic out_free;     // output register empty
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/lrci_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrci_ctrl
// Sequencer: accept word, set up divide, divide, blend channels, emit pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrci_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire lrci_pkg::dp_stat_t stat_i,
  output lrci_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PREP  = 5'b00010,
    S_DIV   = 5'b00100,
    S_BLEND = 5'b01000,
    S_PUSH  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (stat_i.is_step && stat_i.line_active) state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = stat_i.den_zero ? S_BLEND : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_BLEND;
      end
      S_BLEND: begin
        cmd_o.blend_step = 1'b1;
        if (stat_i.blend_last) state_d = S_PUSH;
      end
      S_PUSH: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lrci_dp.sv -----
// ----------------------------------------------------------------------------
// lrci_dp
// Datapath: octant fold, Bresenham walker, weight divider, channel blender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrci_dp #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lrci_pkg::dp_cmd_t            cmd_i,
  output lrci_pkg::dp_stat_t                stat_o,
  input  wire logic                         cmd_bit_i,
  input  wire logic signed [COORD_BITS-1:0] start_x_i,
  input  wire logic signed [COORD_BITS-1:0] start_y_i,
  input  wire logic signed [COORD_BITS-1:0] finish_x_i,
  input  wire logic signed [COORD_BITS-1:0] finish_y_i,
  input  wire logic [31:0]                  start_rgba_i,
  input  wire logic [31:0]                  finish_rgba_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0]      pixel_x_o,
  output logic signed [COORD_BITS-1:0]      pixel_y_o,
  output logic [31:0]                       pixel_rgba_o,
  output logic                              last_o
);

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned DW   = C + 4;                    // decision terms
  localparam int unsigned QW   = C + 1 + lrci_pkg::W_BITS; // dividend
  localparam int unsigned CNTW = $clog2(QW + 1);

  // Line state
  logic signed [C-1:0]  orig_sx_q, orig_sy_q;
  logic signed [C:0]    major_q, minor_q;
  logic signed [DW-1:0] decision_q, diag_q, straight_q;
  logic [C:0]           left_q;
  logic                 mirror_x_q, mirror_y_q, swap_q, active_q, sel_y_q;
  logic [C-1:0]         den_q;
  logic [31:0]          color_a_q, color_b_q;

  // Current pixel
  logic signed [C-1:0]  pix_x_q, pix_y_q;
  logic                 pix_last_q;

  // Divider and blender
  logic [C:0]           rem_q;
  logic [QW-1:0]        quo_q;
  logic [CNTW-1:0]      cnt_q;
  logic [1:0]           ch_q;
  logic [31:0]          rgba_q;

  // Output register
  logic                 out_valid_q;
  logic signed [C-1:0]  out_x_q, out_y_q;
  logic [31:0]          out_rgba_q;
  logic                 out_last_q;

  // ---- load: fold into the first octant ----
  logic signed [C:0]    sx_e, sy_e, fx_e, fy_e, sxn, syn, fxn, fyn;
  logic signed [C+1:0]  ddx, ddy, dmaj, dmin;
  logic                 ld_mx, ld_my, ld_swap, ld_sel_y;
  logic signed [DW-1:0] dmaj_e, dmin_e;

  always_comb begin
    sx_e     = (C+1)'(start_x_i);
    sy_e     = (C+1)'(start_y_i);
    fx_e     = (C+1)'(finish_x_i);
    fy_e     = (C+1)'(finish_y_i);
    ld_mx    = finish_x_i < start_x_i;
    ld_my    = finish_y_i < start_y_i;
    sxn      = ld_mx ? -sx_e : sx_e;
    fxn      = ld_mx ? -fx_e : fx_e;
    syn      = ld_my ? -sy_e : sy_e;
    fyn      = ld_my ? -fy_e : fy_e;
    ddx      = (C+2)'(fxn) - (C+2)'(sxn);
    ddy      = (C+2)'(fyn) - (C+2)'(syn);
    ld_swap  = ddy > ddx;
    dmaj     = ld_swap ? ddy : ddx;
    dmin     = ld_swap ? ddx : ddy;
    dmaj_e   = DW'(dmaj);
    dmin_e   = DW'(dmin);
    ld_sel_y = start_y_i != finish_y_i;
  end

  // ---- step: unfold the walker position ----
  logic signed [C:0]   ux, uy, px, py;
  logic signed [C:0]   ndiff;
  logic [C:0]          num;

  always_comb begin
    ux    = swap_q ? minor_q : major_q;
    uy    = swap_q ? major_q : minor_q;
    px    = mirror_x_q ? -ux : ux;
    py    = mirror_y_q ? -uy : uy;
    ndiff = sel_y_q ? ((C+1)'(pix_y_q) - (C+1)'(orig_sy_q))
                    : ((C+1)'(pix_x_q) - (C+1)'(orig_sx_q));
    num   = ndiff[C] ? $unsigned(-ndiff) : $unsigned(ndiff);
  end

  // ---- restoring divide, one quotient bit per cycle ----
  logic [C:0]  trial, den_e;
  logic        fits;

  always_comb begin
    den_e = (C+1)'(den_q);
    trial = {rem_q[C-1:0], quo_q[QW-1]};
    fits  = trial >= den_e;
  end

  // ---- channel blend: s*2^16 + (e - s)*w + half ----
  logic [lrci_pkg::W_BITS-1:0] weight;
  logic [7:0]                  cs, ce;
  logic signed [8:0]           cdiff;
  logic signed [16:0]          w_s;
  logic signed [25:0]          prod, vsum;
  logic [7:0]                  chan;

  always_comb begin
    weight = (|quo_q[QW-1:lrci_pkg::W_BITS]) ? '1 : quo_q[lrci_pkg::W_BITS-1:0];
    cs     = color_a_q[ch_q*lrci_pkg::CH_BITS +: lrci_pkg::CH_BITS];
    ce     = color_b_q[ch_q*lrci_pkg::CH_BITS +: lrci_pkg::CH_BITS];
    cdiff  = $signed({1'b0, ce}) - $signed({1'b0, cs});
    w_s    = $signed({1'b0, weight});
    prod   = 26'(cdiff * w_s);
    vsum   = $signed({2'b00, cs, 16'h0000}) + prod + 26'sd32768;
    if (vsum[25]) begin
      chan = 8'h00;
    end else if (vsum[24]) begin
      chan = 8'hFF;
    end else begin
      chan = vsum[23:16];
    end
  end

  // Status
  always_comb begin
    stat_o.is_step     = cmd_bit_i == lrci_pkg::CMD_STEP;
    stat_o.line_active = active_q;
    stat_o.den_zero    = den_q == '0;
    stat_o.div_last    = cnt_q == CNTW'(1);
    stat_o.blend_last  = ch_q == 2'd0;
    stat_o.out_free    = !out_valid_q;
  end

  // Control state of the line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      mirror_x_q <= 1'b0;
      mirror_y_q <= 1'b0;
      swap_q     <= 1'b0;
      sel_y_q    <= 1'b0;
      left_q     <= '0;
    end else if (cmd_i.take) begin
      if (cmd_bit_i == lrci_pkg::CMD_LOAD) begin
        active_q   <= 1'b1;
        mirror_x_q <= ld_mx;
        mirror_y_q <= ld_my;
        swap_q     <= ld_swap;
        sel_y_q    <= ld_sel_y;
        left_q     <= dmaj[C:0] + (C+1)'(1);
      end else if (active_q) begin
        left_q <= left_q - (C+1)'(1);
        if (left_q <= (C+1)'(1)) active_q <= 1'b0;
      end
    end
  end

  // Walker and line payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      if (cmd_bit_i == lrci_pkg::CMD_LOAD) begin
        orig_sx_q  <= start_x_i;
        orig_sy_q  <= start_y_i;
        color_a_q  <= start_rgba_i;
        color_b_q  <= finish_rgba_i;
        major_q    <= ld_swap ? syn : sxn;
        minor_q    <= ld_swap ? sxn : syn;
        decision_q <= (dmin_e <<< 1) - dmaj_e;
        diag_q     <= (dmin_e - dmaj_e) <<< 1;
        straight_q <= dmin_e <<< 1;
        den_q      <= ld_sel_y ? ddy[C-1:0] : ddx[C-1:0];
      end else if (active_q) begin
        pix_x_q    <= px[C-1:0];
        pix_y_q    <= py[C-1:0];
        pix_last_q <= left_q == (C+1)'(1);
        if (decision_q > 0) begin
          minor_q    <= minor_q + (C+1)'(1);
          decision_q <= decision_q + diag_q;
        end else begin
          decision_q <= decision_q + straight_q;
        end
        major_q <= major_q + (C+1)'(1);
      end
    end
  end

  // Divider and blender registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      rem_q  <= '0;
      quo_q  <= (den_q == '0) ? '0
              : ({num, {lrci_pkg::W_BITS{1'b0}}} + QW'(den_q >> 1));
      cnt_q  <= CNTW'(QW);
      ch_q   <= 2'(lrci_pkg::CH_NUM - 1);
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? (trial - den_e) : trial;
      quo_q <= {quo_q[QW-2:0], fits};
      cnt_q <= cnt_q - CNTW'(1);
    end else if (cmd_i.blend_step) begin
      rgba_q <= {rgba_q[23:0], chan};
      ch_q   <= ch_q - 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_x_q    <= pix_x_q;
      out_y_q    <= pix_y_q;
      out_rgba_q <= rgba_q;
      out_last_q <= pix_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = out_x_q;
  assign pixel_y_o    = out_y_q;
  assign pixel_rgba_o = out_rgba_q;
  assign last_o       = out_last_q;

endmodule

`default_nettype wire

// ----- hdl/line_raster_color_interp_unit.sv -----
// ----------------------------------------------------------------------------
// line_raster_color_interp_unit
// Bresenham line walker with per-pixel RGBA interpolation.
//
//   channel  direction  handshake                word
//   in       input      in_valid_i / in_ready_o  cmd, endpoints, colors
//   out      output     out_valid_o / out_ready_i pixel x, y, rgba, last
//
// A load word is accepted and latched in the idle state. A step word is
// accepted, sets up the divider, runs COORD_BITS + 17 divide iterations
// for the weight, blends 4 channels and pushes the pixel. A zero-span
// line skips the divide. The output register lets a new word enter
// while a pixel waits; a step stalls before its push until that register
// drains.
// Reset clears the controller and the line's control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module line_raster_color_interp_unit #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         cmd_i,
  input  wire logic signed [COORD_BITS-1:0] start_x_i,
  input  wire logic signed [COORD_BITS-1:0] start_y_i,
  input  wire logic signed [COORD_BITS-1:0] finish_x_i,
  input  wire logic signed [COORD_BITS-1:0] finish_y_i,
  input  wire logic [31:0]                  start_rgba_i,
  input  wire logic [31:0]                  finish_rgba_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0]      pixel_x_o,
  output logic signed [COORD_BITS-1:0]      pixel_y_o,
  output logic [31:0]                       pixel_rgba_o,
  output logic                              last_o
);

  lrci_pkg::dp_cmd_t  dp_cmd;
  lrci_pkg::dp_stat_t dp_stat;
  logic               idle_step;

  // Sequencer
  lrci_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // Datapath
  lrci_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .cmd_bit_i     (cmd_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .finish_x_i    (finish_x_i),
    .finish_y_i    (finish_y_i),
    .start_rgba_i  (start_rgba_i),
    .finish_rgba_i (finish_rgba_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_rgba_o  (pixel_rgba_o),
    .last_o        (last_o)
  );

  // Accepted step word with no line loaded
  assign idle_step = in_valid_i && in_ready_o && (cmd_i == lrci_pkg::CMD_STEP) &&
                     !dp_stat.line_active;

  // A step on an idle line produces nothing and leaves the input open
  `LRCI_ASSERT_NEXT(a_idle_step, idle_step, in_ready_o, "step without a line did not return to idle")
  // A new output word only appears after a push
  `LRCI_ASSERT(a_push_src, $rose(out_valid_o) |-> $past(dp_cmd.push), "output word without push")
  // Input is closed while the divider runs
  `LRCI_ASSERT(a_div_busy, dp_cmd.div_step |-> !in_ready_o, "input open during divide")

endmodule

`default_nettype wire
